>>> hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the sorted set table
// Capacity, derived widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY  = 64;
  localparam int ELEM_W    = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OUT_CNT_W = 7;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_MEMBER = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_DEL,
    ST_RESP
  } state_t;

endpackage

>>> hdl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table: ordered set of distinct signed 32-bit values
// Member test, insert, delete and clear on a single-port-pair store.
// ----------------------------------------------------------------------------
// Use: one word on the in_ channel carries an operation in in_tuser and a
// value in in_tdata. Every word returns exactly one word on the out_
// channel with found, status (set full on insert) and the new count.
// One item at a time: in_tready is high only while the sequencer is idle.
// A lookup walks the store from the lowest entry with one comparator, one
// entry per cycle behind the registered read port. Insert then moves the
// larger entries up and delete moves them down, one entry per cycle
// through the same read and write port pair. Clear skips the walk and
// goes straight to the response state. The next item is accepted in the
// cycle after the result register loads.
// Reset empties the set at once; the store needs no clearing pass.
// When the receiver stalls, the finished word holds in the output
// register; the next item is still accepted and runs, and its result
// waits until the held word is taken.
// ----------------------------------------------------------------------------
module sorted_set_table
  import sst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] element
  input  logic [1:0]            in_tuser,   // [1:0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] found, [1] status, [8:2] count
);

  state_t              state_r, state_nxt;
  func_t               func_r, func_nxt;
  logic [ELEM_W-1:0]   elem_r, elem_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ridx_r, ridx_nxt;
  logic                chk_r, chk_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic                full_r, full_nxt;
  logic [CNT_W-1:0]    sidx_r, sidx_nxt;
  logic [CNT_W-1:0]    wdst_r, wdst_nxt;
  logic                wpend_r, wpend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0] out_count_r, out_count_nxt;

  logic [ELEM_W-1:0]   mem [CAPACITY];
  logic [ELEM_W-1:0]   rdata_r;
  logic                mem_re, mem_we;
  logic [IDX_W-1:0]    mem_raddr, mem_waddr;
  logic [ELEM_W-1:0]   mem_wdata;

  logic                in_fire, out_load;
  logic                lt, eq, stop_hit, more, scan_done, found_fin;
  logic [CNT_W-1:0]    pos_fin;
  logic                ins_move, del_move;
  logic [CNT_W-1:0]    sidx_inc;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

  assign in_fire  = in_tvalid && in_tready;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  // shared compare unit: stored entry against the requested value
  assign lt        = $signed(rdata_r) < $signed(elem_r);
  assign eq        = rdata_r == elem_r;
  assign stop_hit  = chk_r && !lt;
  assign more      = ridx_r < count_r;
  assign scan_done = stop_hit || !more;
  assign pos_fin   = stop_hit ? (ridx_r - CNT_W'(1)) : count_r;
  assign found_fin = stop_hit && eq;

  assign sidx_inc = sidx_r + CNT_W'(1);
  assign ins_move = sidx_r > pos_r;
  assign del_move = sidx_inc < count_r;

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, count_nxt};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (func_t'(in_tuser) == FUNC_CLEAR) state_nxt = ST_RESP;
          else                                 state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          case (func_r)
            FUNC_INSERT: begin
              if (!found_fin && (count_r != CNT_W'(CAPACITY))) state_nxt = ST_INS;
              else                                              state_nxt = ST_RESP;
            end
            FUNC_DELETE: begin
              if (found_fin) state_nxt = ST_DEL;
              else           state_nxt = ST_RESP;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_INS: begin
        if (!ins_move && !wpend_r) state_nxt = ST_RESP;
      end
      ST_DEL: begin
        if (!del_move && !wpend_r) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    func_nxt       = func_r;
    elem_nxt       = elem_r;
    count_nxt      = count_r;
    ridx_nxt       = ridx_r;
    chk_nxt        = chk_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    full_nxt       = full_r;
    sidx_nxt       = sidx_r;
    wdst_nxt       = wdst_r;
    wpend_nxt      = wpend_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_raddr      = ridx_r[IDX_W-1:0];
    mem_waddr      = wdst_r[IDX_W-1:0];
    mem_wdata      = rdata_r;
    in_tready      = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt  = func_t'(in_tuser);
          elem_nxt  = in_tdata[ELEM_W-1:0];
          ridx_nxt  = '0;
          chk_nxt   = 1'b0;
          found_nxt = 1'b0;
          full_nxt  = 1'b0;
          wpend_nxt = 1'b0;
          if (func_t'(in_tuser) == FUNC_CLEAR) count_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          pos_nxt   = pos_fin;
          found_nxt = found_fin;
          chk_nxt   = 1'b0;
          full_nxt  = (func_r == FUNC_INSERT) && !found_fin &&
                      (count_r == CNT_W'(CAPACITY));
          sidx_nxt  = (func_r == FUNC_DELETE) ? pos_fin : count_r;
        end else begin
          // issue the next read; compare it next cycle
          mem_re   = 1'b1;
          ridx_nxt = ridx_r + CNT_W'(1);
          chk_nxt  = 1'b1;
        end
      end
      ST_INS: begin
        if (wpend_r) mem_we = 1'b1;
        if (ins_move) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(sidx_r - CNT_W'(1));
          wdst_nxt  = sidx_r;
          sidx_nxt  = sidx_r - CNT_W'(1);
          wpend_nxt = 1'b1;
        end else if (wpend_r) begin
          wpend_nxt = 1'b0;
        end else begin
          // drop the new value into its slot
          mem_we    = 1'b1;
          mem_waddr = pos_r[IDX_W-1:0];
          mem_wdata = elem_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_DEL: begin
        if (wpend_r) mem_we = 1'b1;
        if (del_move) begin
          mem_re    = 1'b1;
          mem_raddr = sidx_inc[IDX_W-1:0];
          wdst_nxt  = sidx_r;
          sidx_nxt  = sidx_inc;
          wpend_nxt = 1'b1;
        end else if (wpend_r) begin
          wpend_nxt = 1'b0;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_status_nxt = full_r;
          out_count_nxt  = cnt_ext[OUT_CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      chk_r       <= 1'b0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_r       <= chk_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    elem_r       <= elem_nxt;
    ridx_r       <= ridx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    full_r       <= full_nxt;
    sidx_r       <= sidx_nxt;
    wdst_r       <= wdst_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // value store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_CNT_W - 2){1'b0}},
                       out_count_r, out_status_r, out_found_r};

endmodule
